@@ src/abst_pkg.sv @@
`default_nettype none

package abst_pkg;

    // Field widths
    localparam int OP_W     = 2;
    localparam int KEY_W    = 32;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 8;
    localparam int SUM_W    = 40;
    localparam int HT_W     = 4;

    // Default tree size
    localparam int TABLE_SLOTS_DEF = 255;

    // Opcodes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_ROOM   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
    localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd5;

    // Command handed from front end to engine
    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic signed [KEY_W-1:0] key;
    } t_cmd;

    // Result handed from engine to output stage
    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [SLOT_W-1:0]       slot;
        logic signed [SUM_W-1:0] sum;
        logic signed [HT_W-1:0]  height;
    } t_res;

    // Engine sequencer
    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_EMIT
    } t_eng_state;

endpackage

`default_nettype wire

@@ src/abst_front.sv @@
`default_nettype none

module abst_front
    import abst_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic [OP_W-1:0]         i_op,
    input  wire logic signed [KEY_W-1:0] i_key,
    output logic                         o_cmd_valid,
    output t_cmd                         o_cmd,
    input  wire logic                    i_cmd_pop
);

    localparam int Q_DEPTH = 2;
    localparam int CNT_W   = $clog2(Q_DEPTH + 1);

    t_cmd             r_q [Q_DEPTH];
    logic             r_wp;
    logic             r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             push;
    logic             pop;

    // NOP opcode (3) is taken and dropped here
    assign o_ready     = (r_cnt != CNT_W'(Q_DEPTH));
    assign push        = i_valid && o_ready && (i_op != OP_NOP);
    assign pop         = i_cmd_pop && (r_cnt != '0);
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{op: i_op, key: i_key};
        end
    end

    // Queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            if (push && !pop)      r_cnt <= r_cnt + 1'b1;
            else if (pop && !push) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

`default_nettype wire

@@ src/abst_engine.sv @@
`default_nettype none

module abst_engine
    import abst_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cmd_valid,
    input  wire t_cmd i_cmd,
    output logic      o_cmd_pop,
    output logic      o_res_valid,
    output t_res      o_res,
    input  wire logic i_res_ready
);

    localparam int IDX_W   = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int DEPTH_W = $clog2(IDX_W + 1);
    localparam int HGT_W   = DEPTH_W + 1;

    t_eng_state              r_state, n_state;
    t_cmd                    r_cmd;
    logic [IDX_W-1:0]        r_idx;
    logic [DEPTH_W-1:0]      r_depth;
    logic [KEY_W-1:0]        r_mem [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0]  r_valid;
    logic signed [KEY_W-1:0] r_rkey;
    logic                    r_rvld;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [HGT_W-1:0] r_height;
    logic [STATUS_W-1:0]     r_status;
    logic [IDX_W-1:0]        r_slot;

    logic [IDX_W-1:0]        rd_addr;
    logic                    key_lt;
    logic                    key_eq;
    logic [IDX_W+1:0]        nxt_wide;
    logic                    nxt_out;
    logic                    do_insert;
    logic                    do_clear;
    logic                    fin;
    logic [STATUS_W-1:0]     fin_status;
    logic [IDX_W-1:0]        fin_slot;
    logic [IDX_W+7:0]        slot_ext;
    logic signed [HGT_W+3:0] ht_ext;

    // Key compare and child index; two spare bits hold 2*idx+2 for any table size
    assign key_lt   = (r_cmd.key < r_rkey);
    assign key_eq   = (r_cmd.key == r_rkey);
    assign nxt_wide = {1'b0, r_idx, 1'b0} + (IDX_W+2)'(key_lt ? 1 : 2);
    assign nxt_out  = (nxt_wide >= (IDX_W+2)'(TABLE_SLOTS));

    // Sequencer: next state, read address, walk outcome
    always_comb begin
        n_state    = r_state;
        o_cmd_pop  = 1'b0;
        rd_addr    = '0;
        do_insert  = 1'b0;
        do_clear   = 1'b0;
        fin        = 1'b0;
        fin_status = ST_NOT_FOUND;
        fin_slot   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.op == OP_CLEAR) begin
                        do_clear   = 1'b1;
                        fin        = 1'b1;
                        fin_status = ST_CLEARED;
                        n_state    = S_EMIT;
                    end else begin
                        n_state = S_WALK;
                    end
                end
            end
            S_WALK: begin
                rd_addr = nxt_wide[IDX_W-1:0];
                if (!r_rvld) begin
                    fin = 1'b1;
                    if (r_cmd.op == OP_INSERT) begin
                        do_insert  = 1'b1;
                        fin_status = ST_INSERTED;
                        fin_slot   = r_idx;
                    end else begin
                        fin_status = ST_NOT_FOUND;
                    end
                end else if (key_eq) begin
                    fin        = 1'b1;
                    fin_status = (r_cmd.op == OP_INSERT) ? ST_DUPLICATE : ST_FOUND;
                    fin_slot   = r_idx;
                end else if (nxt_out) begin
                    fin        = 1'b1;
                    fin_status = (r_cmd.op == OP_INSERT) ? ST_NO_ROOM : ST_NOT_FOUND;
                end
                if (fin) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_res_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Key store: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (do_insert) r_mem[r_idx] <= r_cmd.key;
        r_rkey <= r_mem[rd_addr];
        r_rvld <= r_valid[rd_addr];
    end

    // Command, walk position and result payload
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd   <= i_cmd;
            r_idx   <= '0;
            r_depth <= '0;
        end else if (r_state == S_WALK && !fin) begin
            r_idx   <= nxt_wide[IDX_W-1:0];
            r_depth <= r_depth + 1'b1;
        end
        if (fin) begin
            r_status <= fin_status;
            r_slot   <= fin_slot;
        end
    end

    // Control state, valid bits, running sum and height
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_sum    <= '0;
            r_height <= -HGT_W'(1);
        end else begin
            r_state <= n_state;
            if (do_clear) begin
                r_valid  <= '0;
                r_sum    <= '0;
                r_height <= -HGT_W'(1);
            end else if (do_insert) begin
                r_valid[r_idx] <= 1'b1;
                r_sum <= r_sum + {{(SUM_W-KEY_W){r_cmd.key[KEY_W-1]}}, r_cmd.key};
                if ($signed({1'b0, r_depth}) > r_height) begin
                    r_height <= $signed({1'b0, r_depth});
                end
            end
        end
    end

    // Result view, slot and height masked to port widths
    assign slot_ext    = {8'd0, r_slot};
    assign ht_ext      = {{4{r_height[HGT_W-1]}}, r_height};
    assign o_res_valid = (r_state == S_EMIT);
    assign o_res       = '{status: r_status, slot: slot_ext[SLOT_W-1:0],
                           sum: r_sum, height: ht_ext[HT_W-1:0]};

    // Walk never stands on a slot beyond the table
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (IDX_W+1)'(r_idx) < (IDX_W+1)'(TABLE_SLOTS))
        else $error("walk index beyond table");

    // Insert only ever fills an empty slot
    a_fill_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_insert |-> !r_valid[r_idx])
        else $error("insert over occupied slot");

    // Empty tree holds no valid slot and a zero sum
    a_empty_tree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_height == -HGT_W'(1)) |-> (r_valid == '0 && r_sum == '0))
        else $error("empty tree with stored keys");

    // A finished walk shows its result on the next cycle
    a_fin_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin |=> o_res_valid)
        else $error("finished walk without result");

endmodule

`default_nettype wire

@@ src/abst_out.sv @@
`default_nettype none

module abst_out
    import abst_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_res_valid,
    input  wire t_res i_res,
    output logic      o_res_ready,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_res      o_res
);

    logic r_full;
    t_res r_res;

    // Output register frees when its transfer completes
    assign o_res_ready = !r_full || i_ready;
    assign o_valid     = r_full;
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (i_res_valid && o_res_ready) r_res <= i_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (o_res_ready) begin
            r_full <= i_res_valid;
        end
    end

endmodule

`default_nettype wire

@@ src/array_bst_insert_search.sv @@
// Channel   Dir  tdata                               tuser
// s_axis    in   [31:0] key                           [1:0] opcode
// m_axis    out  [7:0] slot_index, [47:8] key_sum,    [2:0] status
//                [51:48] tree_height, [55:52] zero
//
// Insert/search walk the tree to the depth d where the walk stops (d up to 7
// at 255 slots): one key-store read per tree level. Clear skips the walk.
// Items run one at a time through the engine; a 2-entry queue takes input
// transfers while the engine works, and the output register holds a result
// under back-pressure. Reset (synchronous) empties the tree at once.
`default_nettype none

module array_bst_insert_search
    import abst_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // [31:0] key
    input  wire logic [1:0]  s_axis_tuser,  // [1:0] opcode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,  // [7:0] slot, [47:8] sum, [51:48] height
    output logic [2:0]       m_axis_tuser   // [2:0] status
);

    logic cmd_valid;
    t_cmd cmd;
    logic cmd_pop;
    logic res_valid;
    t_res res;
    logic res_ready;
    t_res out_res;

    abst_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_op        (s_axis_tuser),
        .i_key       ($signed(s_axis_tdata)),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    abst_engine #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    abst_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_res_ready (res_ready),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_res       (out_res)
    );

    // Pack result fields
    assign m_axis_tdata = {4'd0, out_res.height, out_res.sum, out_res.slot};
    assign m_axis_tuser = out_res.status;

endmodule

`default_nettype wire

@@ verif/array_bst_insert_search_test.sv @@
`default_nettype none

module array_bst_insert_search_test
    import abst_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_SLOTS = TABLE_SLOTS_DEF;
    // Cycles with no transfer on either side before the run is abandoned
    localparam int QUIET_LIMIT = 5000;
    // Margin after the last expected result; this covers a trailing opcode 3 too
    localparam int DRAIN_CYCLES = 40;
    localparam int LONG_HOLD = 300;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // [31:0] key
    logic [1:0]  s_axis_tuser = '0;   // [1:0] opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;        // [7:0] slot, [47:8] sum, [51:48] height, [55:52] zero
    logic [2:0]  m_axis_tuser;        // [2:0] status

    array_bst_insert_search #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Shadow of the tree
    logic signed [KEY_W-1:0] tree_keys [TABLE_SLOTS];
    bit                      tree_valid [TABLE_SLOTS];
    logic signed [SUM_W-1:0] tree_sum;
    logic signed [HT_W-1:0]  tree_height;

    t_res pending_results [$];

    int  mismatches = 0;
    int  ops_sent = 0;
    int  results_seen = 0;
    int  status_seen [6];
    bit  idle_off = 1'b0;
    int  hold_cycles = 0;
    int  quiet_cycles = 0;

    // 2 ns clock
    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Work out the result of one operation and update the shadow tree.
    // Returns 0 when the operation gives no result.
    function automatic bit apply_tree_op(input logic [OP_W-1:0] op,
                                         input logic signed [KEY_W-1:0] key,
                                         output t_res res);
        int unsigned idx;
        int          depth;
        bit          done;
        res = '0;
        if (op == OP_NOP)
            return 1'b0;
        if (op == OP_CLEAR) begin
            foreach (tree_valid[i]) tree_valid[i] = 1'b0;
            tree_sum = '0;
            tree_height = -1;
            res.status = ST_CLEARED;
        end else begin
            idx = 0;
            depth = 0;
            done = 1'b0;
            while (!done) begin
                // bound check comes before the slot is looked at
                if (idx >= TABLE_SLOTS) begin
                    res.status = (op == OP_INSERT) ? ST_NO_ROOM : ST_NOT_FOUND;
                    done = 1'b1;
                end else if (!tree_valid[idx]) begin
                    if (op == OP_INSERT) begin
                        tree_keys[idx] = key;
                        tree_valid[idx] = 1'b1;
                        tree_sum = tree_sum + {{(SUM_W-KEY_W){key[KEY_W-1]}}, key};
                        if (depth > int'(tree_height))
                            tree_height = HT_W'(depth);
                        res.status = ST_INSERTED;
                        res.slot = SLOT_W'(idx);
                    end else begin
                        res.status = ST_NOT_FOUND;
                    end
                    done = 1'b1;
                end else if (key < tree_keys[idx]) begin
                    idx = 2 * idx + 1;
                    depth++;
                end else if (key > tree_keys[idx]) begin
                    idx = 2 * idx + 2;
                    depth++;
                end else begin
                    res.status = (op == OP_INSERT) ? ST_DUPLICATE : ST_FOUND;
                    res.slot = SLOT_W'(idx);
                    done = 1'b1;
                end
            end
        end
        res.sum = tree_sum;
        res.height = tree_height;
        return 1'b1;
    endfunction

    // Offer one operation and wait for its transfer; tvalid stays high afterwards
    task automatic send_op(input logic [OP_W-1:0] op, input logic signed [KEY_W-1:0] key);
        int   gap;
        t_res res;
        gap = idle_off ? 0 : $urandom_range(0, 9);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= key;
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        if (apply_tree_op(op, key, res)) begin
            pending_results.push_back(res);
            ops_sent++;
        end
    endtask

    // Result sink: random stall per result, or a long hold when asked
    initial begin : result_sink
        int stall;
        wait (i_rst_n);
        forever begin
            if (hold_cycles > 0) begin
                stall = hold_cycles;
                hold_cycles = 0;
            end else begin
                stall = idle_off ? 0 : $urandom_range(0, 9);
            end
            @(negedge i_clk);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    // Compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_res got;
        t_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status = m_axis_tuser;
            got.slot   = m_axis_tdata[7:0];
            got.sum    = m_axis_tdata[47:8];
            got.height = m_axis_tdata[51:48];
            results_seen++;
            if (got.status <= ST_CLEARED)
                status_seen[got.status]++;
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: status %0d slot %0d",
                       got.status, got.slot);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, got.status);
                    mismatches++;
                end
                if (got.slot !== want.slot) begin
                    $error("slot_index: expected %0d, actual %0d", want.slot, got.slot);
                    mismatches++;
                end
                if (got.sum !== want.sum) begin
                    $error("key_sum: expected %0d, actual %0d", want.sum, got.sum);
                    mismatches++;
                end
                if (got.height !== want.height) begin
                    $error("tree_height: expected %0d, actual %0d",
                           want.height, got.height);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: give up after a long stretch with no transfer at all
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $error("no transfer for %0d cycles, %0d results outstanding",
                   QUIET_LIMIT, pending_results.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // Key extremes, duplicates, search hit and miss, opcode 3, clear
    task automatic test_basic_ops();
        send_op(OP_SEARCH, 32'sd0);          // empty tree
        send_op(OP_INSERT, 32'sd0);          // root
        send_op(OP_INSERT, 32'sh8000_0000);  // most negative, left child
        send_op(OP_INSERT, 32'sh7fff_ffff);  // most positive, right child
        send_op(OP_INSERT, 32'sd0);          // duplicate of the root
        send_op(OP_SEARCH, 32'sh8000_0000);
        send_op(OP_SEARCH, 32'sh7fff_ffff);
        send_op(OP_SEARCH, 32'sd5);          // misses below the right child
        send_op(OP_NOP, 32'shffff_ffff);     // ignored, no result
        send_op(OP_CLEAR, 32'sh1234_5678);
        send_op(OP_SEARCH, 32'sd0);          // keys kept but no longer valid
    endtask

    // Ascending keys build the right spine down to slot 254, then run out of room
    task automatic test_spine_overflow();
        send_op(OP_CLEAR, 32'sd0);
        for (int k = 1; k <= 8; k++)
            send_op(OP_INSERT, k);
        send_op(OP_INSERT, 32'sd9);          // next index is past the array
        send_op(OP_SEARCH, 32'sd9);          // search runs off the array too
        send_op(OP_SEARCH, 32'sd8);          // deepest slot
        send_op(OP_INSERT, 32'sd8);          // duplicate at the deepest slot
    endtask

    // Random sessions: mostly a clear followed by inserts and searches on a
    // small key pool, some ordered ladders that run out of room, some noise
    task automatic test_random_sessions(input int n_items);
        logic signed [KEY_W-1:0] pool [16];
        logic signed [KEY_W-1:0] key;
        logic signed [KEY_W-1:0] base;
        logic [OP_W-1:0]         op;
        int                      start;
        int                      len;
        int                      step;
        int                      pick;
        bit                      ascending;
        start = ops_sent;
        while (ops_sent - start < n_items) begin
            idle_off = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 5) != 0)
                send_op(OP_CLEAR, $urandom);
            if ($urandom_range(0, 4) == 0) begin
                // ordered ladder
                base = $urandom;
                step = $urandom_range(1, 1000);
                ascending = $urandom_range(0, 1);
                len = $urandom_range(6, 11);
                for (int i = 0; i < len; i++)
                    send_op(OP_INSERT, ascending ? base + i * step : base - i * step);
                for (int i = 0; i < len; i++)
                    send_op(OP_SEARCH, ascending ? base + i * step : base - i * step);
            end else begin
                foreach (pool[i]) begin
                    pick = $urandom_range(0, 9);
                    if (pick == 0)
                        pool[i] = 32'sh8000_0000;
                    else if (pick == 1)
                        pool[i] = 32'sh7fff_ffff;
                    else if (pick == 2)
                        pool[i] = $urandom_range(0, 15) - 8;
                    else
                        pool[i] = $urandom;
                end
                len = $urandom_range(10, 60);
                for (int i = 0; i < len; i++) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 50)
                        op = OP_INSERT;
                    else if (pick < 93)
                        op = OP_SEARCH;
                    else if (pick < 96)
                        op = OP_CLEAR;
                    else
                        op = OP_NOP;
                    key = ($urandom_range(0, 3) == 0) ? $urandom
                                                      : pool[$urandom_range(0, 15)];
                    send_op(op, key);
                end
            end
        end
        idle_off = 1'b0;
    endtask

    // Sink holds off for a long stretch while the source keeps offering
    task automatic test_output_stall();
        idle_off = 1'b1;
        hold_cycles = LONG_HOLD;
        send_op(OP_CLEAR, 32'sd0);
        for (int i = 0; i < 24; i++)
            send_op(($urandom_range(0, 1) == 0) ? OP_INSERT : OP_SEARCH,
                    $urandom_range(0, 31) - 16);
        idle_off = 1'b0;
    endtask

    initial begin
        foreach (tree_valid[i]) tree_valid[i] = 1'b0;
        foreach (status_seen[i]) status_seen[i] = 0;
        tree_sum = '0;
        tree_height = -1;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_ops();
        test_spine_overflow();
        test_output_stall();
        test_random_sessions(1000);
        test_output_stall();

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d operations, %0d results checked, including long output stalls.",
                 ops_sent, results_seen);
        $display("Inserted %0d, duplicate %0d, no room %0d, found %0d, not found %0d, clear %0d.",
                 status_seen[ST_INSERTED], status_seen[ST_DUPLICATE],
                 status_seen[ST_NO_ROOM], status_seen[ST_FOUND],
                 status_seen[ST_NOT_FOUND], status_seen[ST_CLEARED]);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
